// ===== src/mcc_pkg.sv =====
// package for the morse code codec: job record, character codes and the code table
// no dependencies; imported by every module of the block

package mcc_pkg;

  localparam int MAX_SYMBOLS_DEF = 5;   // default depth of the decode symbol buffer
  localparam int JOB_FIFO_DEPTH  = 4;   // default depth of the front-to-back job queue
  localparam int TABLE_ROWS      = 27;  // A..Z and space
  localparam int PATTERN_MAX     = 4;   // longest pattern in the table
  localparam int ROW_W           = 5;
  localparam int LEN_W           = 3;

  localparam logic [ROW_W-1:0] ROW_SPACE = ROW_W'(26);

  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_GAP   = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UZ    = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LZ    = 8'h7A;  // 'z'
  localparam logic [7:0] CASE_OFS = 8'h20;  // lower to upper case distance

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef enum logic [1:0] {
    JOB_ENC,   // emit the pattern of a row, then '#'
    JOB_DEC,   // emit the character of a row
    JOB_ERR    // emit one error result
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [ROW_W-1:0] row;
  } job_t;

  // pattern characters, first symbol in the top byte, unused bytes are spaces
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [31:0]      pat;
  } code_entry_t;

  function automatic code_entry_t code_entry(input logic [ROW_W-1:0] row);
    code_entry_t e;
    case (row)
      5'd0:    e = '{len: 3'd2, pat: ".-  "};
      5'd1:    e = '{len: 3'd4, pat: "-..."};
      5'd2:    e = '{len: 3'd4, pat: "-.-."};
      5'd3:    e = '{len: 3'd3, pat: "-.. "};
      5'd4:    e = '{len: 3'd1, pat: ".   "};
      5'd5:    e = '{len: 3'd4, pat: "..-."};
      5'd6:    e = '{len: 3'd3, pat: "--. "};
      5'd7:    e = '{len: 3'd4, pat: "...."};
      5'd8:    e = '{len: 3'd2, pat: "..  "};
      5'd9:    e = '{len: 3'd4, pat: ".---"};
      5'd10:   e = '{len: 3'd3, pat: "-.- "};
      5'd11:   e = '{len: 3'd4, pat: ".-.."};
      5'd12:   e = '{len: 3'd2, pat: "--  "};
      5'd13:   e = '{len: 3'd2, pat: "-.  "};
      5'd14:   e = '{len: 3'd3, pat: "--- "};
      5'd15:   e = '{len: 3'd4, pat: ".--."};
      5'd16:   e = '{len: 3'd4, pat: "--.-"};
      5'd17:   e = '{len: 3'd3, pat: ".-. "};
      5'd18:   e = '{len: 3'd3, pat: "... "};
      5'd19:   e = '{len: 3'd1, pat: "-   "};
      5'd20:   e = '{len: 3'd3, pat: "..- "};
      5'd21:   e = '{len: 3'd4, pat: "...-"};
      5'd22:   e = '{len: 3'd3, pat: ".-- "};
      5'd23:   e = '{len: 3'd4, pat: "-..-"};
      5'd24:   e = '{len: 3'd4, pat: "-.--"};
      5'd25:   e = '{len: 3'd4, pat: "--.."};
      5'd26:   e = '{len: 3'd2, pat: "$$  "};
      default: e = '{len: 3'd0, pat: 32'h0};
    endcase
    return e;
  endfunction

  function automatic logic [7:0] row_char(input logic [ROW_W-1:0] row);
    return (row < ROW_SPACE) ? (CH_UA + {3'b000, row}) : CH_SPACE;
  endfunction

endpackage

// ===== src/mcc_front.sv =====
// front end of the morse code codec: accepts items, keeps the decode buffer and
// error latch, and queues one job per item that has results; depends on mcc_pkg

module mcc_front #(
  parameter int MAX_SYMBOLS = mcc_pkg::MAX_SYMBOLS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          command,
  input  logic [7:0]    in_char,
  input  logic          start_of_message,
  input  logic          job_full,
  output logic          job_push,
  output mcc_pkg::job_t job_data
);
  import mcc_pkg::*;

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int IDX_W = $clog2(MAX_SYMBOLS);

  logic             err_r, err_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       buf_r [MAX_SYMBOLS];
  logic             buf_wr;

  logic             accept;
  logic             err_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic [7:0]       uc;
  logic             hit;
  logic [ROW_W-1:0] hit_row;

  assign in_ready = !job_full;
  assign accept   = in_valid && !job_full;
  assign err_eff  = start_of_message ? 1'b0 : err_r;
  assign cnt_eff  = start_of_message ? '0 : cnt_r;
  assign uc       = (in_char inside {[CH_LA:CH_LZ]}) ? (in_char - CASE_OFS) : in_char;

  // pattern lookup over all table rows, only the first cnt_eff entries take part
  always_comb begin
    code_entry_t e;
    logic        same;
    hit     = 1'b0;
    hit_row = '0;
    for (int r = 0; r < TABLE_ROWS; r++) begin
      e    = code_entry(ROW_W'(r));
      same = (CNT_W'(e.len) == cnt_eff);
      for (int i = 0; i < PATTERN_MAX; i++) begin
        if (LEN_W'(i) < e.len && buf_r[i] != e.pat[8*(PATTERN_MAX-1-i) +: 8]) begin
          same = 1'b0;
        end
      end
      if (same && !hit) begin
        hit     = 1'b1;
        hit_row = ROW_W'(r);
      end
    end
  end

  always_comb begin
    err_nxt  = err_r;
    cnt_nxt  = cnt_r;
    buf_wr   = 1'b0;
    job_push = 1'b0;
    job_data = '{kind: JOB_ERR, row: '0};
    if (accept) begin
      err_nxt = err_eff;
      cnt_nxt = cnt_eff;
      if (err_eff) begin
        job_push = 1'b1;
      end else if (command == CMD_ENCODE) begin
        job_push = 1'b1;
        if (uc inside {[CH_UA:CH_UZ]}) begin
          job_data = '{kind: JOB_ENC, row: ROW_W'(uc - CH_UA)};
        end else if (uc == CH_SPACE) begin
          job_data = '{kind: JOB_ENC, row: ROW_SPACE};
        end
      end else if (in_char inside {CH_DOT, CH_DASH, CH_GAP}) begin
        if (cnt_eff == CNT_W'(MAX_SYMBOLS)) begin
          job_push = 1'b1;
        end else begin
          buf_wr  = 1'b1;
          cnt_nxt = cnt_eff + 1'b1;
        end
      end else begin
        job_push = 1'b1;
        if (in_char == CH_END && hit) begin
          job_data = '{kind: JOB_DEC, row: hit_row};
          cnt_nxt  = '0;
        end
      end
      if (job_push && job_data.kind == JOB_ERR) begin
        err_nxt = 1'b1;
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      err_r <= err_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_wr) begin
      buf_r[cnt_eff[IDX_W-1:0]] <= in_char;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SYMBOLS))
    else $error("symbol count beyond buffer depth");

endmodule

// ===== src/mcc_job_fifo.sv =====
// short job queue between the front and back ends of the morse code codec
// depends on mcc_pkg for the job record

module mcc_job_fifo #(
  parameter int DEPTH = mcc_pkg::JOB_FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mcc_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output mcc_pkg::job_t head
);
  import mcc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into a full queue");

endmodule

// ===== src/mcc_back.sv =====
// back end of the morse code codec: expands queued jobs into result transactions,
// one per cycle unless out_ready stalls them, through an output register; depends on mcc_pkg

module mcc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_empty,
  input  mcc_pkg::job_t job_head,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          out_last,
  output logic          out_error
);
  import mcc_pkg::*;

  logic             busy_r, busy_nxt;
  job_t             job_r;
  logic [LEN_W-1:0] idx_r;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_last_r;
  logic             out_error_r;

  logic             can_load, cur_ok, fire;
  job_t             cur_job;
  logic [LEN_W-1:0] idx;
  code_entry_t      ent;
  logic [7:0]       res_char;
  logic             res_last, res_error;

  assign can_load = !out_valid_r || out_ready;
  assign cur_job  = busy_r ? job_r : job_head;
  assign cur_ok   = busy_r || !job_empty;
  assign idx      = busy_r ? idx_r : '0;
  assign fire     = can_load && cur_ok;
  assign job_pop  = fire && !busy_r;
  assign ent      = code_entry(cur_job.row);

  always_comb begin
    res_char  = 8'h00;
    res_last  = 1'b1;
    res_error = 1'b0;
    case (cur_job.kind)
      JOB_ENC: begin
        if (idx < ent.len) begin
          res_last = 1'b0;
          case (idx[1:0])
            2'd0:    res_char = ent.pat[31:24];
            2'd1:    res_char = ent.pat[23:16];
            2'd2:    res_char = ent.pat[15:8];
            default: res_char = ent.pat[7:0];
          endcase
        end else begin
          res_char = CH_END;
        end
      end
      JOB_DEC: res_char = row_char(cur_job.row);
      default: res_error = 1'b1;
    endcase
  end

  assign busy_nxt = fire ? !res_last : busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (can_load) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      job_r       <= cur_job;
      idx_r       <= idx + 1'b1;
      out_char_r  <= res_char;
      out_last_r  <= res_last;
      out_error_r <= res_error;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign out_error = out_error_r;

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_error_r |-> out_char_r == 8'h00 && out_last_r)
    else $error("error result not a single zero result");

  a_busy_enc: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> job_r.kind == JOB_ENC)
    else $error("multi-result job that is not an encode");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !busy_r && !job_empty)
    else $error("job taken while previous job still expanding");

endmodule

// ===== src/morse_code_codec.sv =====
// top level of the morse code codec: front end, job queue and back end
// depends on mcc_pkg, mcc_front, mcc_job_fifo and mcc_back

// Encodes text to Morse and decodes Morse to text, one character per input
// transaction (in_tuser[0] = 0 encode, 1 decode; in_tuser[1] starts a message,
// clearing the error latch and the symbol buffer). The front end takes one input
// transaction per cycle whenever the job queue (FIFO_DEPTH entries) has room; the
// back end sends one result transaction per cycle unless out_tready stalls it. An
// encoded letter yields its pattern length plus one results, a space 3, a decoded
// '#' or an error 1, and a buffered decode symbol none. Sustained rate is therefore
// set by the back end's one-result-per-cycle output register.

module morse_code_codec #(
  parameter int MAX_SYMBOLS = mcc_pkg::MAX_SYMBOLS_DEF,
  parameter int FIFO_DEPTH  = mcc_pkg::JOB_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_char
  input  logic [1:0] in_tuser,    // [0] command, [1] start_of_message
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_char
  output logic       out_tlast,
  output logic [0:0] out_tuser    // [0] error
);
  import mcc_pkg::*;

  logic job_push, job_full, job_pop, job_empty;
  job_t job_in, job_head;

  mcc_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .command          (in_tuser[0]),
    .in_char          (in_tdata),
    .start_of_message (in_tuser[1]),
    .job_full         (job_full),
    .job_push         (job_push),
    .job_data         (job_in)
  );

  mcc_job_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .empty     (job_empty),
    .head      (job_head)
  );

  mcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast),
    .out_error (out_tuser[0])
  );

endmodule

// ===== sim/tb_morse_code_codec.sv =====
// testbench for morse_code_codec: encode/decode traffic checked against a built-in predictor
// depends on mcc_pkg and the morse_code_codec rtl; self-checking, no external files

module tb_morse_code_codec;
  timeunit 1ns;
  timeprecision 1ps;

  import mcc_pkg::*;

  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned TAIL_CYCLES     = 20;
  localparam int unsigned ITEMS_PER_PHASE = 56;
  localparam int unsigned MAX_REPORTS     = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } morse_out_t;

  // predicts the codec output per accepted character and checks what comes out
  class morse_checker;
    morse_out_t  expected_chars[$];
    logic [7:0]  sym_buf[MAX_SYMBOLS_DEF];
    int unsigned sym_cnt;
    bit          err_latched;
    int unsigned fails;
    string       code_pat[TABLE_ROWS];

    function new();
      code_pat = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                   ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                   "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..", "$$"};
      sym_cnt     = 0;
      err_latched = 1'b0;
      fails       = 0;
    endfunction

    function void flag_error();
      err_latched = 1'b1;
      sym_cnt     = 0;
      expected_chars.push_back('{ch: 8'h00, last: 1'b1, err: 1'b1});
    endfunction

    function void encode_char(logic [7:0] ch);
      int    row;
      string pat;
      if (ch >= CH_LA && ch <= CH_LZ) ch = ch - CASE_OFS;
      if (ch >= CH_UA && ch <= CH_UZ) begin
        row = int'(ch - CH_UA);
      end else if (ch == CH_SPACE) begin
        row = int'(ROW_SPACE);
      end else begin
        flag_error();
        return;
      end
      pat = code_pat[row];
      for (int i = 0; i < pat.len(); i++)
        expected_chars.push_back('{ch: pat[i], last: 1'b0, err: 1'b0});
      expected_chars.push_back('{ch: CH_END, last: 1'b1, err: 1'b0});
    endfunction

    function void decode_symbol(logic [7:0] ch);
      bit         same;
      logic [7:0] letter;
      if (ch == CH_DOT || ch == CH_DASH || ch == CH_GAP) begin
        if (sym_cnt >= MAX_SYMBOLS_DEF) begin
          flag_error();
        end else begin
          sym_buf[sym_cnt] = ch;
          sym_cnt++;
        end
        return;
      end
      if (ch != CH_END) begin
        flag_error();
        return;
      end
      // an empty buffer matches no row and falls through to the error
      for (int r = 0; r < TABLE_ROWS; r++) begin
        if (code_pat[r].len() != sym_cnt) continue;
        same = 1'b1;
        for (int i = 0; i < sym_cnt; i++)
          if (code_pat[r][i] != sym_buf[i]) same = 1'b0;
        if (same) begin
          sym_cnt = 0;
          letter  = (r < int'(ROW_SPACE)) ? CH_UA + 8'(r) : CH_SPACE;
          expected_chars.push_back('{ch: letter, last: 1'b1, err: 1'b0});
          return;
        end
      end
      flag_error();
    endfunction

    function void note_char(logic cmd, logic [7:0] ch, logic som);
      if (som) begin
        err_latched = 1'b0;
        sym_cnt     = 0;
      end
      if (err_latched) flag_error();
      else if (cmd == CMD_ENCODE) encode_char(ch);
      else decode_symbol(ch);
    endfunction

    function void check_char(morse_out_t got);
      morse_out_t want;
      if (expected_chars.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual char %h last %b error %b",
                   $time, got.ch, got.last, got.err);
        return;
      end
      want = expected_chars.pop_front();
      if (got.ch !== want.ch) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: out_char expected %h actual %h", $time, want.ch, got.ch);
      end
      if (got.last !== want.last) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: last expected %b actual %b", $time, want.last, got.last);
      end
      if (got.err !== want.err) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: error expected %b actual %b", $time, want.err, got.err);
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;   // [7:0] in_char
  logic [1:0] in_tuser   = 2'b00;   // [0] command, [1] start_of_message
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;            // [7:0] out_char
  logic       out_tlast;
  logic [0:0] out_tuser;            // [0] error

  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct     = 0;
  int unsigned  chars_sent    = 0;
  int unsigned  quiet_cycles  = 0;
  morse_checker morse_sb      = new();

  morse_code_codec u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      morse_sb.check_char('{ch: out_tdata, last: out_tlast, err: out_tuser[0]});
  end

  // counts cycles without any transaction on either side
  initial begin
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic [7:0] ch, input logic som);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = ch;
    in_tuser  = {som, cmd};
    do @(posedge clk); while (!in_tready);
    morse_sb.note_char(cmd, ch, som);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_str(input logic cmd, input string s, input logic som);
    for (int i = 0; i < s.len(); i++)
      send_item(cmd, s[i], (i == 0) ? som : 1'b0);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (morse_sb.expected_chars.size() != 0) @(negedge clk);
  endtask

  // mostly restart after an error so that sequences get past the latch
  function automatic logic pick_som();
    if (morse_sb.err_latched) return $urandom_range(7) != 0;
    return $urandom_range(24) == 0;
  endfunction

  function automatic logic [7:0] rand_sym();
    case ($urandom_range(2))
      0:       return CH_DOT;
      1:       return CH_DASH;
      default: return CH_GAP;
    endcase
  endfunction

  task automatic random_traffic(input int unsigned n);
    int unsigned stop;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  ch;
    string       pat;
    stop = chars_sent + n;
    while (chars_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        case ($urandom_range(9))
          0:       ch = CH_SPACE;
          1:       ch = 8'($urandom);
          2, 3, 4: ch = CH_LA + 8'($urandom_range(25));
          default: ch = CH_UA + 8'($urandom_range(25));
        endcase
        send_item(CMD_ENCODE, ch, pick_som());
      end else if (pick < 85) begin
        // a valid pattern, with a rare restart in the middle
        pat = morse_sb.code_pat[$urandom_range(TABLE_ROWS - 1)];
        send_item(CMD_DECODE, pat[0], pick_som());
        for (int i = 1; i < pat.len(); i++)
          send_item(CMD_DECODE, pat[i], $urandom_range(49) == 0);
        send_item(CMD_DECODE, CH_END, 1'b0);
      end else if (pick < 93) begin
        // random symbol strings, six or seven of them overflow the buffer
        len = $urandom_range(7, 1);
        send_item(CMD_DECODE, rand_sym(), pick_som());
        repeat (len - 1) send_item(CMD_DECODE, rand_sym(), 1'b0);
        send_item(CMD_DECODE, CH_END, 1'b0);
      end else begin
        send_item(logic'($urandom_range(1)), 8'($urandom), $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_str(CMD_ENCODE, "Az N", 1'b1);
    send_item(CMD_ENCODE, 8'h00, 1'b0);      // not a letter
    send_item(CMD_ENCODE, "E", 1'b0);        // held off by the error latch
    send_item(CMD_ENCODE, 8'hFF, 1'b1);
    send_str(CMD_DECODE, ".-#", 1'b1);
    send_str(CMD_DECODE, "$$#", 1'b0);
    send_item(CMD_DECODE, CH_END, 1'b0);     // empty buffer
    send_str(CMD_DECODE, "......", 1'b1);    // sixth symbol overflows
    send_item(CMD_DECODE, "x", 1'b1);
    send_item(CMD_DECODE, CH_DASH, 1'b1);
    send_str(CMD_DECODE, ".#", 1'b1);        // restart drops the buffered dash
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 55;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 55;
        end
        default: begin
          send_idle_pct = 20;
          stall_pct     = 20;
        end
      endcase
      random_traffic(ITEMS_PER_PHASE);
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (morse_sb.fails == 0 && morse_sb.expected_chars.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
